FILE: rtl/core/assert_macros.svh
// Assertion macros for the checker file of the stack core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds in the same cycle as the trigger.
`define FDSA_ASSERT_IMP(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error("stack core check failed");

// The condition holds in the cycle after the trigger.
`define FDSA_ASSERT_NXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("stack core check failed");

`endif

FILE: rtl/core/fdsa_pkg.sv
// Types, codes and arithmetic helpers of the Forth data stack core.
`default_nettype none
package fdsa_pkg;

  localparam logic [63:0] PosMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NegMin = 64'h8000_0000_0000_0000;

  typedef enum logic [3:0] {
    CMD_PUSH  = 4'd0,
    CMD_DUP   = 4'd1,
    CMD_DROP  = 4'd2,
    CMD_ADD   = 4'd3,
    CMD_MUL   = 4'd4,
    CMD_SUB   = 4'd5,
    CMD_DIV   = 4'd6,
    CMD_PRINT = 4'd7,
    CMD_SWAP  = 4'd8,
    CMD_OVER  = 4'd9,
    CMD_ROT   = 4'd10
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DIV_ZERO  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_ADDR,
    S_RD_DATA,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_FIN,
    S_WR,
    S_DONE
  } state_e;

  // Number of entries a word consumes from the top of the stack.
  function automatic logic [1:0] need_of(cmd_e c);
    logic [1:0] n;
    unique case (c)
      CMD_DUP, CMD_DROP, CMD_PRINT: n = 2'd1;
      CMD_ADD, CMD_MUL, CMD_SUB, CMD_DIV, CMD_SWAP, CMD_OVER: n = 2'd2;
      CMD_ROT: n = 2'd3;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  // Whether a word adds an entry to the stack.
  function automatic logic grow_of(cmd_e c);
    return (c == CMD_PUSH) || (c == CMD_DUP) || (c == CMD_OVER);
  endfunction

  // Number of memory writes a word performs.
  function automatic logic [1:0] nwr_of(cmd_e c);
    logic [1:0] n;
    unique case (c)
      CMD_PUSH, CMD_DUP, CMD_OVER, CMD_ADD, CMD_MUL, CMD_SUB, CMD_DIV: n = 2'd1;
      CMD_SWAP: n = 2'd2;
      CMD_ROT:  n = 2'd3;
      default:  n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [63:0] mag_of(logic [63:0] x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

  // Sign and 128-bit magnitude to a saturated 64-bit value.
  function automatic logic [63:0] pack(logic neg, logic [127:0] m);
    logic [63:0] r;
    if (!neg) begin
      r = (m[127:63] != '0) ? PosMax : m[63:0];
    end else begin
      r = ((m[127:64] != '0) || (m[63:0] > NegMin)) ? NegMin : (~m[63:0] + 64'd1);
    end
    return r;
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if ((a[63] == b[63]) && (r[63] != a[63])) begin
      r = a[63] ? NegMin : PosMax;
    end
    return r;
  endfunction

  function automatic logic [63:0] sat_sub(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if ((a[63] != b[63]) && (r[63] != a[63])) begin
      r = a[63] ? NegMin : PosMax;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/forth_data_stack_alu_core.sv
// Forth data stack core: stack memory, word sequencer and fixed-point unit.
// A word reads the entries it consumes and then writes its results back to the stack memory;
// multiply and divide run in their own states, the divider at one quotient bit a cycle.
// Words are taken one at a time, and a divide is the slowest word.
// Reset clears the stack count and the handshake state; the stack memory is not cleared.
// A finished result waits in the output register while the next word is taken.
`default_nettype none
module forth_data_stack_alu_core #(
  parameter int STACK_DEPTH = 64,
  parameter int FRAC_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [3:0] cmd, [34:4] literal
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [1:0] status, [65:2] print_value, [72:66] depth_now
  output logic        m_axis_tuser    // [0] print_valid
);

  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int QW  = 64 + FRAC_BITS;
  localparam int DCW = $clog2(QW);

  fdsa_pkg::state_e state_q, state_d;

  // Control registers.
  logic [CW-1:0]  count_q;
  logic [1:0]     ridx_q, widx_q;
  logic [2:0]     mcnt_q;
  logic [DCW-1:0] dcnt_q;
  logic           out_valid_q;

  // Item and operand registers.
  fdsa_pkg::cmd_e    cmd_q;
  logic [30:0]       lit_q;
  fdsa_pkg::status_e status_q;
  logic [1:0]        need_q;
  logic [63:0]       op_q [3];
  logic [63:0]       res_q;
  logic              pvalid_q;
  logic [63:0]       pval_q;

  // Multiplier and divider registers.
  logic [63:0]  ma_q, mb_q, pp_q, dvs_q, rem_q;
  logic [1:0]   pk_q;
  logic [127:0] acc_q, num_q;
  logic         neg_q;

  // Output register payload.
  logic [1:0]  out_status_q;
  logic        out_pvalid_q;
  logic [63:0] out_pval_q;
  logic [6:0]  out_depth_q;

  // Stack memory.
  logic [63:0]   mem_q [STACK_DEPTH];
  logic [63:0]   rdata_q;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [63:0]   wr_data;

  logic            in_acc, out_load, err;
  fdsa_pkg::cmd_e  in_cmd;
  fdsa_pkg::status_e in_status;
  logic [CW-1:0]   cnt_new;
  logic [CW-1:0]   rd_full, wr_full;
  logic [127:0]    lit_ext, fin_mag;
  logic [31:0]     mul_a, mul_b;
  logic [64:0]     trial;
  logic            trial_ge;
  logic [CW+6:0]   depth_ext;

  assign in_cmd = fdsa_pkg::cmd_e'(s_axis_tdata[3:0]);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign err    = (status_q == fdsa_pkg::ST_UNDERFLOW) || (status_q == fdsa_pkg::ST_OVERFLOW);
  assign out_load = (state_q == fdsa_pkg::S_DONE) && (!out_valid_q || m_axis_tready);

  // Stack check at acceptance.
  always_comb begin
    if (count_q < CW'(fdsa_pkg::need_of(in_cmd))) begin
      in_status = fdsa_pkg::ST_UNDERFLOW;
    end else if (fdsa_pkg::grow_of(in_cmd) && (count_q >= CW'(STACK_DEPTH))) begin
      in_status = fdsa_pkg::ST_OVERFLOW;
    end else begin
      in_status = fdsa_pkg::ST_OK;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fdsa_pkg::S_IDLE: begin
        if (in_acc) begin
          if ((in_status == fdsa_pkg::ST_OK) && (fdsa_pkg::need_of(in_cmd) != 2'd0)) begin
            state_d = fdsa_pkg::S_RD_ADDR;
          end else begin
            state_d = fdsa_pkg::S_EXEC;
          end
        end
      end
      fdsa_pkg::S_RD_ADDR: state_d = fdsa_pkg::S_RD_DATA;
      fdsa_pkg::S_RD_DATA: begin
        state_d = (ridx_q == need_q - 2'd1) ? fdsa_pkg::S_EXEC : fdsa_pkg::S_RD_ADDR;
      end
      fdsa_pkg::S_EXEC: begin
        if (err) begin
          state_d = fdsa_pkg::S_DONE;
        end else if (cmd_q == fdsa_pkg::CMD_MUL) begin
          state_d = fdsa_pkg::S_MUL;
        end else if ((cmd_q == fdsa_pkg::CMD_DIV) && (op_q[0] != '0)) begin
          state_d = fdsa_pkg::S_DIV;
        end else if (fdsa_pkg::nwr_of(cmd_q) != 2'd0) begin
          state_d = fdsa_pkg::S_WR;
        end else begin
          state_d = fdsa_pkg::S_DONE;
        end
      end
      fdsa_pkg::S_MUL: if (mcnt_q == 3'd4) state_d = fdsa_pkg::S_FIN;
      fdsa_pkg::S_DIV: if (dcnt_q == '0) state_d = fdsa_pkg::S_FIN;
      fdsa_pkg::S_FIN: state_d = fdsa_pkg::S_WR;
      fdsa_pkg::S_WR: begin
        if (widx_q == fdsa_pkg::nwr_of(cmd_q) - 2'd1) state_d = fdsa_pkg::S_DONE;
      end
      fdsa_pkg::S_DONE: if (out_load) state_d = fdsa_pkg::S_IDLE;
      default: state_d = fdsa_pkg::S_IDLE;
    endcase
  end

  // Handshake and memory port controls.
  always_comb begin
    s_axis_tready = (state_q == fdsa_pkg::S_IDLE);
    rd_en = (state_q == fdsa_pkg::S_RD_ADDR);
    wr_en = (state_q == fdsa_pkg::S_WR);
  end

  // Read address: the entry ridx places below the top.
  assign rd_full = count_q - CW'(1) - CW'(ridx_q);
  assign rd_addr = rd_full[AW-1:0];

  // Write address and data for each word.
  always_comb begin
    wr_full = count_q;
    wr_data = res_q;
    unique case (cmd_q)
      fdsa_pkg::CMD_PUSH, fdsa_pkg::CMD_DUP, fdsa_pkg::CMD_OVER: wr_full = count_q;
      fdsa_pkg::CMD_SWAP: begin
        wr_full = (widx_q == 2'd0) ? count_q - CW'(1) : count_q - CW'(2);
        wr_data = (widx_q == 2'd0) ? op_q[1] : op_q[0];
      end
      fdsa_pkg::CMD_ROT: begin
        wr_full = count_q - CW'(3) + CW'(widx_q);
        wr_data = (widx_q == 2'd0) ? op_q[1] : ((widx_q == 2'd1) ? op_q[0] : op_q[2]);
      end
      default: wr_full = count_q - CW'(2);
    endcase
  end
  assign wr_addr = wr_full[AW-1:0];

  // Stack memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  // Stack count after the word.
  always_comb begin
    cnt_new = count_q;
    if (!err) begin
      unique case (cmd_q)
        fdsa_pkg::CMD_PUSH, fdsa_pkg::CMD_DUP, fdsa_pkg::CMD_OVER: cnt_new = count_q + CW'(1);
        fdsa_pkg::CMD_DROP, fdsa_pkg::CMD_PRINT, fdsa_pkg::CMD_ADD, fdsa_pkg::CMD_MUL,
        fdsa_pkg::CMD_SUB, fdsa_pkg::CMD_DIV: cnt_new = count_q - CW'(1);
        default: cnt_new = count_q;
      endcase
    end
  end
  assign depth_ext = {7'd0, cnt_new};

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fdsa_pkg::S_IDLE;
      count_q     <= '0;
      ridx_q      <= '0;
      widx_q      <= '0;
      mcnt_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        ridx_q <= '0;
        widx_q <= '0;
      end
      if (state_q == fdsa_pkg::S_RD_DATA) ridx_q <= ridx_q + 2'd1;
      if (state_q == fdsa_pkg::S_WR) widx_q <= widx_q + 2'd1;
      if (state_q == fdsa_pkg::S_EXEC) begin
        mcnt_q <= '0;
        dcnt_q <= DCW'(QW - 1);
      end
      if (state_q == fdsa_pkg::S_MUL) mcnt_q <= mcnt_q + 3'd1;
      if ((state_q == fdsa_pkg::S_DIV) && (dcnt_q != '0)) dcnt_q <= dcnt_q - DCW'(1);
      if (out_load) begin
        count_q     <= cnt_new;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Operand selection for the 32 by 32 partial products.
  always_comb begin
    mul_a = mcnt_q[1] ? ma_q[63:32] : ma_q[31:0];
    mul_b = mcnt_q[0] ? mb_q[63:32] : mb_q[31:0];
  end

  // One restoring division step.
  assign trial    = {rem_q, num_q[QW-1]};
  assign trial_ge = (trial >= {1'b0, dvs_q});

  assign lit_ext = 128'(lit_q) << FRAC_BITS;
  assign fin_mag = (cmd_q == fdsa_pkg::CMD_MUL) ? (acc_q >> FRAC_BITS) : acc_q;

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q    <= in_cmd;
      lit_q    <= s_axis_tdata[34:4];
      status_q <= in_status;
      need_q   <= fdsa_pkg::need_of(in_cmd);
      pvalid_q <= 1'b0;
      pval_q   <= '0;
    end
    if (state_q == fdsa_pkg::S_RD_DATA) op_q[ridx_q] <= rdata_q;
    if ((state_q == fdsa_pkg::S_EXEC) && !err) begin
      neg_q <= op_q[1][63] ^ op_q[0][63];
      ma_q  <= fdsa_pkg::mag_of(op_q[1]);
      mb_q  <= fdsa_pkg::mag_of(op_q[0]);
      num_q <= 128'(fdsa_pkg::mag_of(op_q[1])) << FRAC_BITS;
      dvs_q <= fdsa_pkg::mag_of(op_q[0]);
      rem_q <= '0;
      acc_q <= '0;
      unique case (cmd_q)
        fdsa_pkg::CMD_PUSH: res_q <= fdsa_pkg::pack(1'b0, lit_ext);
        fdsa_pkg::CMD_DUP:  res_q <= op_q[0];
        fdsa_pkg::CMD_OVER: res_q <= op_q[1];
        fdsa_pkg::CMD_ADD:  res_q <= fdsa_pkg::sat_add(op_q[1], op_q[0]);
        fdsa_pkg::CMD_SUB:  res_q <= fdsa_pkg::sat_sub(op_q[1], op_q[0]);
        fdsa_pkg::CMD_DIV: begin
          // Division by zero saturates towards the sign of the dividend; zero over zero gives zero.
          if (op_q[0] == '0) begin
            status_q <= fdsa_pkg::ST_DIV_ZERO;
            res_q <= (op_q[1] == '0) ? '0 :
                     (op_q[1][63] ? fdsa_pkg::NegMin : fdsa_pkg::PosMax);
          end
        end
        fdsa_pkg::CMD_PRINT: begin
          pvalid_q <= 1'b1;
          pval_q   <= op_q[0];
        end
        default: res_q <= res_q;
      endcase
    end
    // Partial products one a cycle, accumulated in the following cycle.
    if (state_q == fdsa_pkg::S_MUL) begin
      pp_q <= 64'(mul_a) * 64'(mul_b);
      pk_q <= mcnt_q[1:0];
      if (mcnt_q != 3'd0) begin
        unique case (pk_q)
          2'd0: acc_q <= acc_q + 128'(pp_q);
          2'd1, 2'd2: acc_q <= acc_q + (128'(pp_q) << 32);
          default: acc_q <= acc_q + (128'(pp_q) << 64);
        endcase
      end
    end
    if (state_q == fdsa_pkg::S_DIV) begin
      num_q <= num_q << 1;
      rem_q <= trial_ge ? 64'(trial - {1'b0, dvs_q}) : trial[63:0];
      acc_q <= {acc_q[126:0], trial_ge};
    end
    if (state_q == fdsa_pkg::S_FIN) res_q <= fdsa_pkg::pack(neg_q, fin_mag);
    if (out_load) begin
      out_status_q <= status_q;
      out_pvalid_q <= pvalid_q;
      out_pval_q   <= pval_q;
      out_depth_q  <= depth_ext[6:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_depth_q, out_pval_q, out_status_q};
  assign m_axis_tuser  = out_pvalid_q;

endmodule
`default_nettype wire

FILE: rtl/core/fdsa_checker.sv
// Port-level checker for the Forth data stack core, with its bind statement.
`default_nettype none
`include "assert_macros.svh"
module fdsa_checker #(
  parameter int STACK_DEPTH = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,   // [1:0] status, [65:2] print_value, [72:66] depth_now
  input logic        m_axis_tuser    // [0] print_valid
);

  localparam logic [6:0] FullDepth = 7'(STACK_DEPTH);

  // A stalled result transaction holds its payload.
  `FDSA_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // Words are executed one at a time, so the input closes after each transaction.
  `FDSA_ASSERT_NXT(a_one_word, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // A printed value comes only from a word that succeeded.
  `FDSA_ASSERT_IMP(a_print_ok, m_axis_tvalid && m_axis_tuser, m_axis_tdata[1:0] == fdsa_pkg::ST_OK)
  // Overflow is reported only with a full stack.
  `FDSA_ASSERT_IMP(a_ovf_full, m_axis_tvalid && (m_axis_tdata[1:0] == fdsa_pkg::ST_OVERFLOW), m_axis_tdata[72:66] == FullDepth)

endmodule

bind forth_data_stack_alu_core fdsa_checker #(.STACK_DEPTH(STACK_DEPTH)) u_fdsa_checker (.*);
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench of the Forth data stack core.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard holding the expected word results in issue order.
class word_result_board;
  typedef struct packed {
    logic [1:0]  status;
    logic        print_valid;
    logic [63:0] print_value;
    logic [6:0]  depth_now;
  } word_result_t;

  localparam int Depth = 64;
  localparam int Frac  = 32;

  logic [63:0]  stack_mem [Depth];
  int unsigned  stack_cnt;
  word_result_t pending_q [$];
  int unsigned  mismatches;
  int unsigned  results_seen;

  function new();
    stack_cnt    = 0;
    mismatches   = 0;
    results_seen = 0;
    foreach (stack_mem[i]) stack_mem[i] = '0;
  endfunction

  // Sign and 128-bit magnitude to a saturated 64-bit value.
  function automatic logic [63:0] saturate(logic neg, logic [127:0] m);
    if (!neg) return (m > 128'h7FFF_FFFF_FFFF_FFFF) ? fdsa_pkg::PosMax : m[63:0];
    if (m > 128'h8000_0000_0000_0000) return fdsa_pkg::NegMin;
    return ~m[63:0] + 64'd1;
  endfunction

  function automatic logic [63:0] magnitude(logic [63:0] x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

  function automatic logic [63:0] fx_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
    return saturate(a[63] ^ b[63], p >> Frac);
  endfunction

  function automatic logic [63:0] fx_quotient(logic [63:0] a, logic [63:0] b);
    logic [127:0] q;
    q = ({64'd0, magnitude(a)} << Frac) / {64'd0, magnitude(b)};
    return saturate(a[63] ^ b[63], q);
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? fdsa_pkg::NegMin : fdsa_pkg::PosMax;
    return r;
  endfunction

  function automatic logic [63:0] sub_sat(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) r = a[63] ? fdsa_pkg::NegMin : fdsa_pkg::PosMax;
    return r;
  endfunction

  // Execute one word on the shadow stack and queue its result.
  function void note_word(logic [3:0] cmd, logic [30:0] lit);
    word_result_t r;
    int unsigned  need, grow, n;
    logic [63:0]  t, u;
    r = '0;
    n = stack_cnt;
    need = 0;
    grow = 0;
    case (cmd)
      fdsa_pkg::CMD_PUSH: grow = 1;
      fdsa_pkg::CMD_DUP: begin
        need = 1;
        grow = 1;
      end
      fdsa_pkg::CMD_DROP, fdsa_pkg::CMD_PRINT: need = 1;
      fdsa_pkg::CMD_ADD, fdsa_pkg::CMD_MUL, fdsa_pkg::CMD_SUB, fdsa_pkg::CMD_DIV,
      fdsa_pkg::CMD_SWAP: need = 2;
      fdsa_pkg::CMD_OVER: begin
        need = 2;
        grow = 1;
      end
      fdsa_pkg::CMD_ROT: need = 3;
      default: ;
    endcase
    if (n < need) begin
      r.status = fdsa_pkg::ST_UNDERFLOW;
    end else if (grow != 0 && n >= Depth) begin
      r.status = fdsa_pkg::ST_OVERFLOW;
    end else begin
      case (cmd)
        fdsa_pkg::CMD_PUSH: begin
          stack_mem[n] = saturate(1'b0, {97'd0, lit} << Frac);
          stack_cnt = n + 1;
        end
        fdsa_pkg::CMD_DUP: begin
          stack_mem[n] = stack_mem[n-1];
          stack_cnt = n + 1;
        end
        fdsa_pkg::CMD_DROP: stack_cnt = n - 1;
        fdsa_pkg::CMD_ADD, fdsa_pkg::CMD_MUL, fdsa_pkg::CMD_SUB, fdsa_pkg::CMD_DIV: begin
          t = stack_mem[n-1];
          u = stack_mem[n-2];
          if (cmd == fdsa_pkg::CMD_ADD) u = add_sat(u, t);
          else if (cmd == fdsa_pkg::CMD_MUL) u = fx_product(u, t);
          else if (cmd == fdsa_pkg::CMD_SUB) u = sub_sat(u, t);
          else if (t == 64'd0) begin
            r.status = fdsa_pkg::ST_DIV_ZERO;
            u = (u == 64'd0) ? 64'd0 : (u[63] ? fdsa_pkg::NegMin : fdsa_pkg::PosMax);
          end else u = fx_quotient(u, t);
          stack_mem[n-2] = u;
          stack_cnt = n - 1;
        end
        fdsa_pkg::CMD_PRINT: begin
          r.print_valid = 1'b1;
          r.print_value = stack_mem[n-1];
          stack_cnt = n - 1;
        end
        fdsa_pkg::CMD_SWAP: begin
          t = stack_mem[n-1];
          stack_mem[n-1] = stack_mem[n-2];
          stack_mem[n-2] = t;
        end
        fdsa_pkg::CMD_OVER: begin
          stack_mem[n] = stack_mem[n-2];
          stack_cnt = n + 1;
        end
        fdsa_pkg::CMD_ROT: begin
          t = stack_mem[n-3];
          stack_mem[n-3] = stack_mem[n-2];
          stack_mem[n-2] = stack_mem[n-1];
          stack_mem[n-1] = t;
        end
        default: ;
      endcase
    end
    r.depth_now = stack_cnt[6:0];
    pending_q.insert(pending_q.size(), r);
  endfunction

  // Compare one result transaction with the oldest expectation.
  function void check_result(logic [79:0] data, logic user);
    word_result_t exp_r, got;
    got.status      = data[1:0];
    got.print_value = data[65:2];
    got.depth_now   = data[72:66];
    got.print_valid = user;
    results_seen++;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result: %p", got);
      return;
    end
    exp_r = pending_q.pop_front();
    if (got !== exp_r) begin
      mismatches++;
      if (mismatches <= 10) $display("Mismatch: expected %p, got %p", exp_r, got);
    end
  endfunction
endclass

module tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;

  word_result_board board = new();
  int unsigned cycle_cnt = 0;
  int unsigned words_sent = 0;
  int unsigned word_kinds [16];
  bit          hold_off = 1'b0;

  forth_data_stack_alu_core dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Cycle limit: the slowest correct run is far below this.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 1_000_000) begin
      $display("forth_data_stack_alu_core test failed");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off when requested.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
      if (hold_off) m_axis_tready <= 1'b0;
      else if ($urandom_range(0, 99) < 8) m_axis_tready <= 1'b0;
      else m_axis_tready <= 1'b1;
    end
  end

  // Mostly no gap or a short one, now and then a long one; some runs without any.
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one word and wait until it is accepted.
  task automatic send_word(logic [3:0] cmd, logic [30:0] lit, bit no_gap = 1'b0);
    int unsigned g;
    g = no_gap ? 0 : gap_len();
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, lit, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_word(cmd, lit);
    word_kinds[cmd]++;
    words_sent++;
  endtask

  function automatic logic [30:0] rand_lit();
    case ($urandom_range(0, 4))
      0: return 31'd0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom_range(0, 15));
      default: return 31'($urandom());
    endcase
  endfunction

  // Random word, biased towards what keeps the stack busy at its depth.
  function automatic logic [3:0] rand_cmd();
    int unsigned d;
    d = board.stack_cnt;
    if ($urandom_range(0, 99) < 3) return 4'($urandom_range(11, 15));
    if (d < 3 && $urandom_range(0, 99) < 60) return fdsa_pkg::CMD_PUSH;
    if (d > 56 && $urandom_range(0, 99) < 50) return fdsa_pkg::CMD_PRINT;
    return 4'($urandom_range(0, 10));
  endfunction

  initial begin
    int unsigned i;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: underflow on an empty stack, then extremes and every word.
    send_word(fdsa_pkg::CMD_DROP, 31'd0);
    send_word(fdsa_pkg::CMD_ROT, 31'd0);
    send_word(fdsa_pkg::CMD_PUSH, 31'h7FFF_FFFF);
    send_word(fdsa_pkg::CMD_DUP, 31'd0);
    send_word(fdsa_pkg::CMD_MUL, 31'd0);        // saturates high
    send_word(fdsa_pkg::CMD_PUSH, 31'd0);
    send_word(fdsa_pkg::CMD_DIV, 31'd0);        // divide by zero, positive dividend
    send_word(fdsa_pkg::CMD_PUSH, 31'd0);
    send_word(fdsa_pkg::CMD_PUSH, 31'd0);
    send_word(fdsa_pkg::CMD_DIV, 31'd0);        // zero over zero
    send_word(fdsa_pkg::CMD_SWAP, 31'd0);
    send_word(fdsa_pkg::CMD_SUB, 31'd0);        // goes to one above the negative limit
    send_word(fdsa_pkg::CMD_PUSH, 31'd7);
    send_word(fdsa_pkg::CMD_SUB, 31'd0);
    send_word(fdsa_pkg::CMD_DUP, 31'd0);
    send_word(fdsa_pkg::CMD_ADD, 31'd0);        // saturates low
    send_word(fdsa_pkg::CMD_PUSH, 31'd0);
    send_word(fdsa_pkg::CMD_DIV, 31'd0);        // divide by zero, negative dividend
    send_word(fdsa_pkg::CMD_PUSH, 31'd3);
    send_word(fdsa_pkg::CMD_OVER, 31'd0);
    send_word(fdsa_pkg::CMD_ROT, 31'd0);
    send_word(fdsa_pkg::CMD_DIV, 31'd0);
    send_word(fdsa_pkg::CMD_PRINT, 31'd0);
    send_word(4'd15, 31'h5555_5555);            // unknown code
    send_word(4'd11, 31'h2AAA_AAAA);

    // Fill to overflow with the result side held off, so the core stalls.
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      while (board.stack_cnt < 64) send_word(fdsa_pkg::CMD_PUSH, rand_lit(), 1'b1);
    join
    send_word(fdsa_pkg::CMD_PUSH, 31'd1);
    send_word(fdsa_pkg::CMD_DUP, 31'd0);
    send_word(fdsa_pkg::CMD_OVER, 31'd0);
    while (board.stack_cnt > 2) send_word(fdsa_pkg::CMD_PRINT, 31'd0);

    // Random words.
    for (i = 0; i < 1300; i++) send_word(rand_cmd(), rand_lit());
    s_axis_tvalid <= 1'b0;

    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    $display("Ran %0d words (%0d divides, %0d multiplies), %0d results checked.",
             words_sent, word_kinds[fdsa_pkg::CMD_DIV], word_kinds[fdsa_pkg::CMD_MUL],
             board.results_seen);
    $display("Covered underflow, overflow at full depth, divide by zero and saturation.");
    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("forth_data_stack_alu_core test passed");
    end else begin
      $display("forth_data_stack_alu_core test failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
